@@ src/wfmd_pkg.sv @@
// Shared types, symbol codes and helpers for the time-code minute decoder.
`default_nettype none
package wfmd_pkg;

	localparam int WinLen = 11;

	localparam logic [7:0] SymSync = 8'h80;
	localparam logic [7:0] SymOne  = 8'hF0;
	localparam logic [7:0] SymZero = 8'hFE;
	localparam logic [7:0] SymBad  = 8'hFF;

	localparam logic [5:0] MinuteLimit = 6'd60;

	localparam logic [1:0] ClsInvalid = 2'd0;
	localparam logic [1:0] ClsZero    = 2'd1;
	localparam logic [1:0] ClsOne     = 2'd2;
	localparam logic [1:0] ClsSync    = 2'd3;

	localparam logic [7:0] HoldoffReset = 8'd60;

	// Register byte address bit 2 selects the register slot.
	localparam logic RegHoldoff = 1'b0;

	typedef logic [WinLen-1:0][7:0] win_t;

	// Tracker to matcher: updated window, holdoff and current class.
	typedef struct packed {
		win_t       win;
		logic [7:0] holdoff;
		logic [1:0] sym_class;
	} trk_t;

	typedef struct packed {
		logic       minute_valid;
		logic [5:0] minute;
		logic [1:0] symbol_class;
	} res_t;

	function automatic logic [1:0] classify(input logic [7:0] s);
		logic [1:0] c;
		case (s)
			SymSync: c = ClsSync;
			SymOne:  c = ClsOne;
			SymZero: c = ClsZero;
			default: c = ClsInvalid;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ src/wwvb_frame_minute_decoder_core.sv @@
// Top level of the time-code minute decoder: stream ports, register port, result register.
// An accepted input beat's result beat appears on m_tvalid in the cycle after the accept.
// Throughput: one beat per clock while m_tready drains the result; window shift, holdoff
// update and decode all settle in the accept cycle and land in a single output register.
// s_tready is high whenever the output register is empty or being drained this cycle.
// Reset (arst_n low, asynchronous): window, holdoff and spacing clear, holdoff_length
// returns to 60, output register empties.
`default_nettype none
module wwvb_frame_minute_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] symbol_byte, [8] strict_checks, [15:9] zero
	input  wire logic        s_tuser,   // [0] receive_error
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [5:0] minute, [7:6] symbol_class
	output logic             m_tuser,   // [0] minute_valid
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic           accept;
	logic [7:0]     holdoff_len_q;
	wfmd_pkg::trk_t trk;
	wfmd_pkg::res_t res;
	wfmd_pkg::res_t res_q;
	logic           out_vld_q;

	// Register port: always ready, one register in slot zero.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_len_q <= wfmd_pkg::HoldoffReset;
		end else if (psel && penable && pwrite && (paddr[2] == wfmd_pkg::RegHoldoff)) begin
			holdoff_len_q <= pwdata[7:0];
		end
	end

	always_comb begin
		case (paddr[2])
			wfmd_pkg::RegHoldoff: prdata = {24'd0, holdoff_len_q};
			default:              prdata = 32'd0;
		endcase
	end

	// A valid beat is taken whenever the result slot is empty or frees up this cycle.
	assign s_tready = !out_vld_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	wfmd_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.symbol_byte   (s_tdata[7:0]),
		.receive_error (s_tuser),
		.strict_checks (s_tdata[8]),
		.holdoff_length(holdoff_len_q),
		.trk           (trk)
	);

	wfmd_match u_match (
		.trk(trk),
		.res(res)
	);

	// Result register: loads on accept, empties when drained with nothing new.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {res_q.symbol_class, res_q.minute};
	assign m_tuser  = res_q.minute_valid;

`ifndef NO_ASSERTIONS
	// A trusted minute is always below sixty.
	a_minute_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[5:0] < wfmd_pkg::MinuteLimit))
		else $error("trusted minute out of range");

	// An untrusted result carries minute zero.
	a_minute_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[5:0] == 6'd0))
		else $error("minute not zero on failed decode");

	// Every accepted beat shows up in the result slot next cycle.
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted beat lost");

	// A result only ever appears if a beat was accepted or one was already waiting.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(accept) && !$past(m_tvalid)) |-> !m_tvalid)
		else $error("result beat without input");
`endif

endmodule
`default_nettype wire

@@ src/wfmd_track.sv @@
// Symbol window shift line, error holdoff and sync spacing counter.
`default_nettype none
module wfmd_track (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  symbol_byte,
	input  wire logic        receive_error,
	input  wire logic        strict_checks,
	input  wire logic [7:0]  holdoff_length,
	output wfmd_pkg::trk_t   trk
);

	wfmd_pkg::win_t win_q;
	logic [7:0]     hold_q;
	logic [7:0]     spacing_q;

	logic [7:0]     sym;
	logic [1:0]     cls;
	logic [7:0]     hold_dec;
	logic [7:0]     sp_inc;
	logic           fail;
	logic [7:0]     hold_next;
	logic [7:0]     sp_next;
	wfmd_pkg::win_t win_next;

	always_comb begin
		sym      = receive_error ? wfmd_pkg::SymBad : symbol_byte;
		cls      = wfmd_pkg::classify(sym);
		win_next = {sym, win_q[wfmd_pkg::WinLen-1:1]};
		hold_dec = (hold_q != 8'd0) ? hold_q - 8'd1 : 8'd0;
		sp_inc   = spacing_q + 8'd1;
		fail     = (cls == wfmd_pkg::ClsInvalid) ||
		           ((sym == wfmd_pkg::SymSync) &&
		            !(sp_inc == 8'd1 || sp_inc == 8'd9 || sp_inc == 8'd10));
		hold_next = (strict_checks && fail) ? holdoff_length : hold_dec;
		if (!strict_checks) begin
			sp_next = spacing_q;
		end else if (sym == wfmd_pkg::SymSync) begin
			sp_next = 8'd0;
		end else begin
			sp_next = sp_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			hold_q    <= 8'd0;
			spacing_q <= 8'd0;
		end else if (accept) begin
			win_q     <= win_next;
			hold_q    <= hold_next;
			spacing_q <= sp_next;
		end
	end

	assign trk.win       = win_next;
	assign trk.holdoff   = hold_next;
	assign trk.sym_class = cls;

endmodule
`default_nettype wire

@@ src/wfmd_match.sv @@
// Frame start match and minute decode over the updated window.
`default_nettype none
module wfmd_match (
	input  wire wfmd_pkg::trk_t trk,
	output wfmd_pkg::res_t      res
);

	logic       frame;
	logic       bits_ok;
	logic [6:0] tens;
	logic [6:0] acc;

	always_comb begin
		frame = (trk.win[0] == wfmd_pkg::SymSync) && (trk.win[1] == wfmd_pkg::SymSync) &&
		        (trk.win[10] == wfmd_pkg::SymSync) && (trk.win[5] == wfmd_pkg::SymZero);
		bits_ok = 1'b1;
		for (int i = 2; i < 10; i++) begin
			if (i != 5) begin
				if (trk.win[i] != wfmd_pkg::SymOne && trk.win[i] != wfmd_pkg::SymZero)
					bits_ok = 1'b0;
			end
		end
		// tens digit 0..7, times ten as x*8 + x*2
		tens = {4'd0, trk.win[2] == wfmd_pkg::SymOne, trk.win[3] == wfmd_pkg::SymOne,
		        trk.win[4] == wfmd_pkg::SymOne};
		acc  = (tens << 3) + (tens << 1) +
		       {3'd0, trk.win[6] == wfmd_pkg::SymOne, trk.win[7] == wfmd_pkg::SymOne,
		        trk.win[8] == wfmd_pkg::SymOne, trk.win[9] == wfmd_pkg::SymOne};
		res.symbol_class = trk.sym_class;
		if (frame && bits_ok && (trk.holdoff == 8'd0) &&
		    (acc < {1'b0, wfmd_pkg::MinuteLimit})) begin
			res.minute_valid = 1'b1;
			res.minute       = acc[5:0];
		end else begin
			res.minute_valid = 1'b0;
			res.minute       = 6'd0;
		end
	end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the time-code minute decoder core.
`default_nettype none
module tb;

	// Generous ceiling: ~1550 beats with idle and stall cycles between them, plus register writes.
	localparam int CycleLimit = 200000;
	localparam int ReportLimit = 10;
	// Byte address of the holdoff length register (register 0 of the map).
	localparam logic [2:0] HoldoffAddr = 3'd0;
	// Minute weight per window position; positions 0, 1, 5 and 10 carry markers.
	localparam int BitWeight [0:10] = '{0, 0, 40, 20, 10, 0, 8, 4, 2, 1, 0};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [7:0] symbol_byte, [8] strict_checks, [15:9] zero
	logic        s_tuser;   // [0] receive_error
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [5:0] minute, [7:6] symbol_class
	logic        m_tuser;   // [0] minute_valid
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	wwvb_frame_minute_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Idle percentages for each side; changed per stimulus phase.
	int tx_idle_pct = 17;
	int rx_idle_pct = 63;

	int errors;
	int cycles;
	int symbols_sent;
	int beats_checked;
	int setting_idx;

	// Decoder mirror: window (newest at 10), holdoff countdown, sync spacing, register.
	logic [7:0] sym_window [0:10];
	logic [7:0] holdoff_cnt;
	logic [7:0] sync_gap;
	logic [7:0] holdoff_len;

	wfmd_pkg::res_t expected_minutes [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure, redrawn each falling edge.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= ReportLimit)
			$display("%s", msg);
	endtask

	function automatic logic [1:0] sym_class(input logic [7:0] s);
		if (s == wfmd_pkg::SymSync)
			return wfmd_pkg::ClsSync;
		if (s == wfmd_pkg::SymOne)
			return wfmd_pkg::ClsOne;
		if (s == wfmd_pkg::SymZero)
			return wfmd_pkg::ClsZero;
		return wfmd_pkg::ClsInvalid;
	endfunction

	// Advance the mirror by one symbol and queue the result beat it should give.
	task automatic predict_minute(input logic [7:0] byte_in, input logic rx_err,
			input logic strict);
		logic [7:0]     s;
		logic           trusted;
		int             acc;
		wfmd_pkg::res_t r;
		s = rx_err ? wfmd_pkg::SymBad : byte_in;
		for (int k = 0; k < 10; k++)
			sym_window[k] = sym_window[k+1];
		sym_window[10] = s;

		// countdown first, so a reload in this beat leaves the full length
		if (holdoff_cnt != 8'd0)
			holdoff_cnt = holdoff_cnt - 8'd1;

		// relaxed mode only counts the holdoff down; it never reloads it and leaves spacing untouched
		if (strict) begin
			if (sym_class(s) == wfmd_pkg::ClsInvalid)
				holdoff_cnt = holdoff_len;
			sync_gap = sync_gap + 8'd1;
			if (s == wfmd_pkg::SymSync) begin
				if (sync_gap != 8'd1 && sync_gap != 8'd9 && sync_gap != 8'd10)
					holdoff_cnt = holdoff_len;
				sync_gap = 8'd0;
			end
		end

		r = '0;
		r.symbol_class = sym_class(s);
		// frame start: sync, sync, zero marker at 5, sync at the newest slot
		if (sym_window[0] == wfmd_pkg::SymSync && sym_window[1] == wfmd_pkg::SymSync &&
				sym_window[10] == wfmd_pkg::SymSync && sym_window[5] == wfmd_pkg::SymZero) begin
			trusted = (holdoff_cnt == 8'd0);
			acc = 0;
			for (int k = 2; k < 10; k++) begin
				if (sym_window[k] != wfmd_pkg::SymOne && sym_window[k] != wfmd_pkg::SymZero)
					trusted = 1'b0;
				if (sym_window[k] == wfmd_pkg::SymOne)
					acc += BitWeight[k];
			end
			// failed decode keeps minute at zero
			if (trusted && acc < wfmd_pkg::MinuteLimit) begin
				r.minute_valid = 1'b1;
				r.minute = acc[5:0];
			end
		end
		expected_minutes.push_back(r);
	endtask

	// Result beats are checked before the input beat of the same edge is predicted,
	// so the oldest expectation always belongs to the beat on the output.
	always @(posedge clk) begin
		wfmd_pkg::res_t got;
		wfmd_pkg::res_t exp;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.minute_valid = m_tuser;
				got.minute = m_tdata[5:0];
				got.symbol_class = m_tdata[7:6];
				if (expected_minutes.size() == 0) begin
					flag_error($sformatf("unexpected result beat: valid %0b minute %0d class %0d",
						got.minute_valid, got.minute, got.symbol_class));
				end else begin
					exp = expected_minutes.pop_front();
					if (got.minute_valid !== exp.minute_valid || got.minute !== exp.minute ||
							got.symbol_class !== exp.symbol_class)
						flag_error($sformatf(
							"beat %0d: exp valid %0b minute %0d class %0d, got %0b %0d %0d",
							beats_checked, exp.minute_valid, exp.minute, exp.symbol_class,
							got.minute_valid, got.minute, got.symbol_class));
				end
				beats_checked++;
			end
			if (s_tvalid && s_tready)
				predict_minute(s_tdata[7:0], s_tuser, s_tdata[8]);
		end
	end

	// One input beat, preceded by random idle cycles; valid stays high back to back.
	task automatic send_symbol(input logic [7:0] sym, input logic rx_err, input logic strict);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, strict, sym};
		s_tuser  <= rx_err;
		do @(posedge clk); while (!s_tready);
		symbols_sent++;
	endtask

	task automatic hold_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Ten symbols of a time-code frame: sync, sync (or data when single_sync), three
	// tens bits, zero marker, four units bits. bad_pos >= 0 spoils one slot.
	task automatic send_time_group(input logic [6:0] bits, input logic strict,
			input logic single_sync, input int bad_pos);
		logic [7:0] slot [0:9];
		logic       err;
		slot[0] = wfmd_pkg::SymSync;
		slot[1] = single_sync ? (bits[0] ? wfmd_pkg::SymOne : wfmd_pkg::SymZero)
		                      : wfmd_pkg::SymSync;
		slot[2] = bits[6] ? wfmd_pkg::SymOne : wfmd_pkg::SymZero;
		slot[3] = bits[5] ? wfmd_pkg::SymOne : wfmd_pkg::SymZero;
		slot[4] = bits[4] ? wfmd_pkg::SymOne : wfmd_pkg::SymZero;
		slot[5] = wfmd_pkg::SymZero;
		slot[6] = bits[3] ? wfmd_pkg::SymOne : wfmd_pkg::SymZero;
		slot[7] = bits[2] ? wfmd_pkg::SymOne : wfmd_pkg::SymZero;
		slot[8] = bits[1] ? wfmd_pkg::SymOne : wfmd_pkg::SymZero;
		slot[9] = bits[0] ? wfmd_pkg::SymOne : wfmd_pkg::SymZero;
		for (int k = 0; k < 10; k++) begin
			err = 1'b0;
			if (k == bad_pos) begin
				if ($urandom_range(1) != 0)
					err = 1'b1;
				else
					slot[k] = 8'($urandom_range(255));
			end
			send_symbol(slot[k], err, strict);
		end
	endtask

	// Register writes only with the stream drained; then read the value back.
	task automatic write_holdoff(input logic [7:0] value);
		hold_input();
		while (expected_minutes.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= HoldoffAddr;
		pwdata  <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		holdoff_len = value;
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {24'd0, value})
			flag_error($sformatf("holdoff readback: exp %0d, got %0d", value, prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Symbol classes and the byte extremes, relaxed so the holdoff stays clear.
	task automatic test_symbol_classes();
		send_symbol(8'h00, 1'b0, 1'b0);
		send_symbol(8'hFF, 1'b0, 1'b0);
		send_symbol(wfmd_pkg::SymSync, 1'b1, 1'b0);   // receive error masks a sync
		send_symbol(wfmd_pkg::SymOne, 1'b0, 1'b0);
		send_symbol(wfmd_pkg::SymZero, 1'b0, 1'b0);
	endtask

	// Minute 59 decodes; the next frame spells 79 and must give a failed decode.
	task automatic test_frame_decode();
		send_time_group(7'b1011001, 1'b1, 1'b0, -1);
		send_time_group(7'b1111001, 1'b1, 1'b0, -1);
		send_symbol(wfmd_pkg::SymSync, 1'b0, 1'b1);
	endtask

	// Mostly well-formed frames with random bits, some spoilt or single-sync frames,
	// and bursts of noise. Holdoff length changes between segments.
	task automatic test_random_stream(input int tx_pct, input int rx_pct, input int n_items);
		int         seg_end;
		int         pick;
		int         burst;
		logic [7:0] sym;
		logic [7:0] setting;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int seg = 0; seg < 3; seg++) begin
			case (setting_idx % 5)
				0:       setting = 8'd0;
				1:       setting = 8'd255;
				2:       setting = wfmd_pkg::HoldoffReset;
				3:       setting = 8'd1;
				default: setting = 8'($urandom_range(2, 40));
			endcase
			setting_idx++;
			write_holdoff(setting);
			seg_end = symbols_sent + n_items / 3;
			while (symbols_sent < seg_end) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					send_time_group(7'($urandom_range(127)), $urandom_range(19) != 0, 1'b0,
						($urandom_range(99) < 12) ? int'($urandom_range(9)) : -1);
				end else if (pick < 90) begin
					send_time_group(7'($urandom_range(127)), 1'b1, 1'b1, -1);
				end else begin
					burst = $urandom_range(1, 12);
					repeat (burst) begin
						case ($urandom_range(7))
							0:       sym = wfmd_pkg::SymSync;
							1:       sym = wfmd_pkg::SymOne;
							2:       sym = wfmd_pkg::SymZero;
							3:       sym = wfmd_pkg::SymBad;
							default: sym = 8'($urandom_range(255));
						endcase
						send_symbol(sym, $urandom_range(9) == 0, $urandom_range(1) != 0);
					end
				end
			end
		end
	endtask

	initial begin
		clk      = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		for (int k = 0; k < 11; k++)
			sym_window[k] = 8'd0;
		holdoff_cnt = 8'd0;
		sync_gap    = 8'd0;
		holdoff_len = wfmd_pkg::HoldoffReset;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_symbol_classes();
		test_frame_decode();
		test_random_stream(17, 63, 508);
		test_random_stream(63, 17, 508);
		test_random_stream(0, 0, 508);

		// drain: every expectation must be met, then let the output register settle
		hold_input();
		while (expected_minutes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
